// ----- design/psu_pkg.sv -----
// Shared types, constants and a helper function of the Phong shading unit.
package psu_pkg;

    // Field widths.
    localparam int unsigned COLOR_W  = 16;
    localparam int unsigned VEC_W    = 16;
    localparam int unsigned OUT_W    = 17;
    localparam int unsigned AD_W     = 19;
    localparam int unsigned RR_W     = 48;
    localparam int unsigned RL_W     = 41;
    localparam int unsigned RLEN_W   = 24;
    localparam int unsigned NUM_W    = 42;
    localparam int unsigned POW_W    = 32;
    localparam int unsigned SHINE_W  = 8;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_W    = 16;

    // Pipeline depths of the units.
    localparam int unsigned GEO_N  = 6;
    localparam int unsigned SQ_N   = RLEN_W;
    localparam int unsigned DIV_QB = OUT_W;
    localparam int unsigned DIV_N  = DIV_QB + 1;
    localparam int unsigned POW_N  = SHINE_W;
    localparam int unsigned MIX_N  = 3;

    // Fixed-point constants.
    localparam logic [POW_W-1:0] Q15_ONE = POW_W'(32768);
    localparam logic [POW_W-1:0] POW_CAP = POW_W'(32'h8000_0000);
    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AMBIENT   = 2'd0,
        CFG_DIFFUSE   = 2'd1,
        CFG_SPECULAR  = 2'd2,
        CFG_SHININESS = 2'd3
    } psu_cfg_e;

    // One shading sample as it enters the pipeline.
    typedef struct packed {
        logic [2:0][COLOR_W-1:0] base;
        logic [COLOR_W-1:0]      factor;
        logic [2:0][VEC_W-1:0]   n;
        logic [2:0][VEC_W-1:0]   l;
    } psu_smp_t;

    // Color data that travels along with the geometry.
    typedef struct packed {
        logic [2:0][COLOR_W-1:0] base;
        logic [2:0][AD_W-1:0]    ad;
    } psu_col_t;

    typedef struct packed {
        logic [RR_W-1:0] rr;
        logic [RL_W-1:0] rl;
        psu_col_t        col;
    } psu_geo_t;

    typedef struct packed {
        logic [RLEN_W-1:0] rlen;
        logic [RL_W-1:0]   rl;
        psu_col_t          col;
    } psu_len_t;

    typedef struct packed {
        logic [OUT_W-1:0] c;
        psu_col_t         col;
    } psu_cos_t;

    typedef struct packed {
        logic [POW_W-1:0] p;
        psu_col_t         col;
    } psu_pwr_t;

    typedef struct packed {
        logic [2:0][OUT_W-1:0] add;
    } psu_res_t;

    // Q15 multiply with saturation at 65536.0.
    function automatic logic [POW_W-1:0] qmul_cap(input logic [POW_W-1:0] a,
                                                  input logic [POW_W-1:0] b);
        logic [2*POW_W-1:0] prod;
        logic [2*POW_W-16:0] shr;
        prod = a * b;
        shr  = prod[2*POW_W-1:15];
        if (shr > (2*POW_W-15)'(POW_CAP))
            return POW_CAP;
        return shr[POW_W-1:0];
    endfunction

endpackage

// ----- design/psu_sample_if.sv -----
// Channel interface that carries one shading sample word.
interface psu_sample_if;
    logic        valid;
    logic        ready;
    logic [15:0] base_red;
    logic [15:0] base_green;
    logic [15:0] base_blue;
    logic [15:0] diffuse_factor;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [15:0] light_x;
    logic signed [15:0] light_y;
    logic signed [15:0] light_z;

    modport source (
        output valid, base_red, base_green, base_blue, diffuse_factor,
        output normal_x, normal_y, normal_z, light_x, light_y, light_z,
        input  ready
    );
    modport sink (
        input  valid, base_red, base_green, base_blue, diffuse_factor,
        input  normal_x, normal_y, normal_z, light_x, light_y, light_z,
        output ready
    );
endinterface

// ----- design/psu_color_if.sv -----
// Channel interface that carries one color contribution word.
interface psu_color_if;
    logic        valid;
    logic        ready;
    logic [16:0] add_red;
    logic [16:0] add_green;
    logic [16:0] add_blue;

    modport source (output valid, add_red, add_green, add_blue, input ready);
    modport sink   (input valid, add_red, add_green, add_blue, output ready);
endinterface

// ----- design/psu_geom.sv -----
// Geometry stages: N.L, reflection vector, |R|^2 and R.L, plus ambient and diffuse.
module psu_geom (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [15:0]           ambient_coef,
    input  logic [15:0]           diffuse_coef,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  psu_pkg::psu_smp_t     in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output psu_pkg::psu_geo_t     out_data
);
    localparam int unsigned N = psu_pkg::GEO_N;

    logic [N-1:0] vld_reg;
    logic [N:0]   ld;

    // Stage 0 registers.
    logic signed [31:0] prod_reg [3];
    logic [16:0]        amb_reg [3];
    logic [16:0]        bd_reg [3];
    logic [15:0]        fac_reg;
    logic signed [15:0] n0_reg [3];
    logic signed [15:0] l0_reg [3];
    logic [15:0]        base0_reg [3];
    // Stage 1 registers.
    logic signed [18:0] dq_reg;
    logic signed [15:0] n1_reg [3];
    logic signed [15:0] l1_reg [3];
    psu_pkg::psu_col_t  col1_reg;
    // Stage 2 registers.
    logic signed [34:0] t_reg [3];
    logic signed [15:0] l2_reg [3];
    psu_pkg::psu_col_t  col2_reg;
    // Stage 3 registers.
    logic signed [22:0] r_reg [3];
    logic signed [15:0] l3_reg [3];
    psu_pkg::psu_col_t  col3_reg;
    // Stage 4 registers.
    logic signed [45:0] sq_reg [3];
    logic signed [38:0] rlp_reg [3];
    psu_pkg::psu_col_t  col4_reg;
    // Stage 5 registers.
    logic [47:0]        rr_reg;
    logic signed [40:0] rl_reg;
    psu_pkg::psu_col_t  col5_reg;

    logic signed [32:0] d28;
    logic [32:0]        dif_prod [3];
    logic signed [36:0] r28 [3];
    logic signed [47:0] rr_sum;

    // A stage loads when it is empty or its successor loads.
    assign ld[N] = out_ready;
    for (genvar i = 0; i < N; i++) begin : g_ld
        assign ld[i] = !vld_reg[i] || ld[i+1];
    end
    assign in_ready  = ld[0];
    assign out_valid = vld_reg[N-1];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (ld[0])
                vld_reg[0] <= in_valid;
            for (int i = 1; i < N; i++)
            begin
                if (ld[i])
                    vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // Combinational helpers between stages.
    always_comb begin
        d28 = 33'(prod_reg[0]) + 33'(prod_reg[1]) + 33'(prod_reg[2]);
        for (int i = 0; i < 3; i++)
        begin
            dif_prod[i] = bd_reg[i] * fac_reg;
            r28[i] = (37'(t_reg[i]) <<< 1) - (37'(l2_reg[i]) <<< 14);
        end
        rr_sum = 48'(sq_reg[0]) + 48'(sq_reg[1]) + 48'(sq_reg[2]);
    end

    // Payload registers.
    always_ff @(posedge clk) begin
        if (ld[0])
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i] <= $signed(in_data.n[i]) * $signed(in_data.l[i]);
                amb_reg[i]  <= 17'((32'(in_data.base[i]) * 32'(ambient_coef)) >> 15);
                bd_reg[i]   <= 17'((32'(in_data.base[i]) * 32'(diffuse_coef)) >> 15);
                n0_reg[i]   <= $signed(in_data.n[i]);
                l0_reg[i]   <= $signed(in_data.l[i]);
                base0_reg[i] <= in_data.base[i];
            end
            fac_reg <= in_data.factor;
        end
        if (ld[1])
        begin
            dq_reg <= d28[32:14];
            for (int i = 0; i < 3; i++)
            begin
                n1_reg[i] <= n0_reg[i];
                l1_reg[i] <= l0_reg[i];
                col1_reg.base[i] <= base0_reg[i];
                col1_reg.ad[i] <= 19'(amb_reg[i]) + 19'(dif_prod[i][32:15]);
            end
        end
        if (ld[2])
        begin
            for (int i = 0; i < 3; i++)
            begin
                t_reg[i]  <= dq_reg * n1_reg[i];
                l2_reg[i] <= l1_reg[i];
            end
            col2_reg <= col1_reg;
        end
        if (ld[3])
        begin
            for (int i = 0; i < 3; i++)
            begin
                r_reg[i]  <= r28[i][36:14];
                l3_reg[i] <= l2_reg[i];
            end
            col3_reg <= col2_reg;
        end
        if (ld[4])
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i]  <= r_reg[i] * r_reg[i];
                rlp_reg[i] <= r_reg[i] * l3_reg[i];
            end
            col4_reg <= col3_reg;
        end
        if (ld[5])
        begin
            rr_reg   <= rr_sum;
            rl_reg   <= 41'(rlp_reg[0]) + 41'(rlp_reg[1]) + 41'(rlp_reg[2]);
            col5_reg <= col4_reg;
        end
    end

    assign out_data.rr  = rr_reg;
    assign out_data.rl  = rl_reg;
    assign out_data.col = col5_reg;
endmodule

// ----- design/psu_sqrt.sv -----
// Integer square root of |R|^2, one result bit per pipeline stage.
module psu_sqrt (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  psu_pkg::psu_geo_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output psu_pkg::psu_len_t out_data
);
    localparam int unsigned N = psu_pkg::SQ_N;
    localparam int unsigned W = psu_pkg::RR_W;

    logic [N-1:0]             vld_reg;
    logic [N:0]               ld;
    logic [W-1:0]             v_reg   [N];
    logic [W-1:0]             res_reg [N];
    logic [psu_pkg::RL_W-1:0] rl_reg  [N];
    psu_pkg::psu_col_t        col_reg [N];

    assign ld[N] = out_ready;
    for (genvar i = 0; i < N; i++) begin : g_ld
        assign ld[i] = !vld_reg[i] || ld[i+1];
    end
    assign in_ready  = ld[0];
    assign out_valid = vld_reg[N-1];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (ld[0])
                vld_reg[0] <= in_valid;
            for (int i = 1; i < N; i++)
            begin
                if (ld[i])
                    vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // Stage j tries the root bit of weight 2^(N-1-j), with trial term 4^(N-1-j).
    for (genvar j = 0; j < N; j++) begin : g_st
        localparam logic [W:0] BIT = (W+1)'(1) << (2 * (N - 1 - j));
        logic [W-1:0] v_in;
        logic [W-1:0] res_in;
        logic [W:0]   trial;
        logic [W-1:0] v_next;
        logic [W-1:0] res_next;

        if (j == 0) begin : g_first
            assign v_in   = in_data.rr;
            assign res_in = '0;
        end
        else begin : g_rest
            assign v_in   = v_reg[j-1];
            assign res_in = res_reg[j-1];
        end

        always_comb begin
            trial = {1'b0, res_in} + BIT;
            if ({1'b0, v_in} >= trial)
            begin
                v_next   = v_in - trial[W-1:0];
                res_next = (res_in >> 1) + BIT[W-1:0];
            end
            else
            begin
                v_next   = v_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge clk) begin
            if (ld[j])
            begin
                v_reg[j]   <= v_next;
                res_reg[j] <= res_next;
                if (j == 0)
                begin
                    rl_reg[j]  <= in_data.rl;
                    col_reg[j] <= in_data.col;
                end
                else
                begin
                    rl_reg[j]  <= rl_reg[j-1];
                    col_reg[j] <= col_reg[j-1];
                end
            end
        end
    end

    assign out_data.rlen = res_reg[N-1][psu_pkg::RLEN_W-1:0];
    assign out_data.rl   = rl_reg[N-1];
    assign out_data.col  = col_reg[N-1];
endmodule

// ----- design/psu_div.sv -----
// Saturating divider for c = 2*(R.L)/|R|, one quotient bit per stage.
module psu_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  psu_pkg::psu_len_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output psu_pkg::psu_cos_t out_data
);
    localparam int unsigned N  = psu_pkg::DIV_N;
    localparam int unsigned QB = psu_pkg::DIV_QB;
    localparam int unsigned NW = psu_pkg::NUM_W;
    localparam int unsigned DW = psu_pkg::RLEN_W;

    logic [N-1:0]      vld_reg;
    logic [N:0]        ld;
    logic [NW-1:0]     rem_reg  [N];
    logic [DW-1:0]     den_reg  [N];
    logic [QB-1:0]     q_reg    [N];
    logic              zero_reg [N];
    logic              sat_reg  [N];
    psu_pkg::psu_col_t col_reg  [N];

    logic          pre_zero;
    logic [NW-1:0] pre_num;
    logic          pre_sat;

    assign ld[N] = out_ready;
    for (genvar i = 0; i < N; i++) begin : g_ld
        assign ld[i] = !vld_reg[i] || ld[i+1];
    end
    assign in_ready  = ld[0];
    assign out_valid = vld_reg[N-1];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (ld[0])
                vld_reg[0] <= in_valid;
            for (int i = 1; i < N; i++)
            begin
                if (ld[i])
                    vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // Special cases: a zero length or a non-positive dot gives zero; a
    // quotient beyond the output range saturates.
    always_comb begin
        pre_zero = (in_data.rlen == '0) || in_data.rl[psu_pkg::RL_W-1]
                   || (in_data.rl == '0);
        pre_num  = {in_data.rl, 1'b0};
        pre_sat  = pre_num >= (NW'(in_data.rlen) << QB);
    end

    always_ff @(posedge clk) begin
        if (ld[0])
        begin
            rem_reg[0]  <= pre_num;
            den_reg[0]  <= in_data.rlen;
            q_reg[0]    <= '0;
            zero_reg[0] <= pre_zero;
            sat_reg[0]  <= pre_sat;
            col_reg[0]  <= in_data.col;
        end
    end

    // Stage j settles quotient bit QB-j.
    for (genvar j = 1; j < N; j++) begin : g_st
        localparam int unsigned K = QB - j;
        logic [NW-1:0] sh;
        logic [NW-1:0] rem_next;
        logic [QB-1:0] q_next;

        always_comb begin
            sh       = NW'(den_reg[j-1]) << K;
            rem_next = rem_reg[j-1];
            q_next   = q_reg[j-1];
            if (rem_reg[j-1] >= sh)
            begin
                rem_next = rem_reg[j-1] - sh;
                q_next[K] = 1'b1;
            end
        end

        always_ff @(posedge clk) begin
            if (ld[j])
            begin
                rem_reg[j]  <= rem_next;
                den_reg[j]  <= den_reg[j-1];
                q_reg[j]    <= q_next;
                zero_reg[j] <= zero_reg[j-1];
                sat_reg[j]  <= sat_reg[j-1];
                col_reg[j]  <= col_reg[j-1];
            end
        end
    end

    always_comb begin
        priority if (zero_reg[N-1])
            out_data.c = '0;
        else if (sat_reg[N-1])
            out_data.c = psu_pkg::OUT_MAX;
        else
            out_data.c = q_reg[N-1];
        out_data.col = col_reg[N-1];
    end
endmodule

// ----- design/psu_pow.sv -----
// Square-and-multiply power of c, one exponent bit per stage.
module psu_pow (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        shininess,
    input  logic              in_valid,
    output logic              in_ready,
    input  psu_pkg::psu_cos_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output psu_pkg::psu_pwr_t out_data
);
    localparam int unsigned N = psu_pkg::POW_N;
    localparam int unsigned W = psu_pkg::POW_W;

    logic [N-1:0]      vld_reg;
    logic [N:0]        ld;
    logic [W-1:0]      p_reg   [N];
    logic [W-1:0]      s_reg   [N];
    psu_pkg::psu_col_t col_reg [N];

    assign ld[N] = out_ready;
    for (genvar i = 0; i < N; i++) begin : g_ld
        assign ld[i] = !vld_reg[i] || ld[i+1];
    end
    assign in_ready  = ld[0];
    assign out_valid = vld_reg[N-1];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (ld[0])
                vld_reg[0] <= in_valid;
            for (int i = 1; i < N; i++)
            begin
                if (ld[i])
                    vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    for (genvar j = 0; j < N; j++) begin : g_st
        logic [W-1:0]      p_in;
        logic [W-1:0]      s_in;
        psu_pkg::psu_col_t col_in;

        if (j == 0) begin : g_first
            assign p_in   = psu_pkg::Q15_ONE;
            assign s_in   = W'(in_data.c);
            assign col_in = in_data.col;
        end
        else begin : g_rest
            assign p_in   = p_reg[j-1];
            assign s_in   = s_reg[j-1];
            assign col_in = col_reg[j-1];
        end

        always_ff @(posedge clk) begin
            if (ld[j])
            begin
                p_reg[j]   <= shininess[j] ? psu_pkg::qmul_cap(p_in, s_in) : p_in;
                s_reg[j]   <= psu_pkg::qmul_cap(s_in, s_in);
                col_reg[j] <= col_in;
            end
        end
    end

    assign out_data.p   = p_reg[N-1];
    assign out_data.col = col_reg[N-1];
endmodule

// ----- design/psu_mix.sv -----
// Specular scaling and the saturating sum of the three terms.
module psu_mix (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [15:0]       specular_coef,
    input  logic              in_valid,
    output logic              in_ready,
    input  psu_pkg::psu_pwr_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output psu_pkg::psu_res_t out_data
);
    localparam int unsigned N = psu_pkg::MIX_N;

    logic [N-1:0]      vld_reg;
    logic [N:0]        ld;
    logic [32:0]       ks_reg;
    psu_pkg::psu_col_t col0_reg;
    logic [33:0]       spc_reg [3];
    logic [psu_pkg::AD_W-1:0] ad1_reg [3];
    logic [psu_pkg::OUT_W-1:0] add_reg [3];

    logic [47:0] ks_prod;
    logic [48:0] spc_prod [3];
    logic [34:0] sum [3];

    assign ld[N] = out_ready;
    for (genvar i = 0; i < N; i++) begin : g_ld
        assign ld[i] = !vld_reg[i] || ld[i+1];
    end
    assign in_ready  = ld[0];
    assign out_valid = vld_reg[N-1];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (ld[0])
                vld_reg[0] <= in_valid;
            for (int i = 1; i < N; i++)
            begin
                if (ld[i])
                    vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_comb begin
        ks_prod = 48'(in_data.p) * 48'(specular_coef);
        for (int i = 0; i < 3; i++)
        begin
            spc_prod[i] = 49'(col0_reg.base[i]) * 49'(ks_reg);
            sum[i] = 35'(ad1_reg[i]) + 35'(spc_reg[i]);
        end
    end

    always_ff @(posedge clk) begin
        if (ld[0])
        begin
            ks_reg   <= ks_prod[47:15];
            col0_reg <= in_data.col;
        end
        if (ld[1])
        begin
            for (int i = 0; i < 3; i++)
            begin
                spc_reg[i] <= spc_prod[i][48:15];
                ad1_reg[i] <= col0_reg.ad[i];
            end
        end
        if (ld[2])
        begin
            // Saturate the sum at the top of the output range.
            for (int i = 0; i < 3; i++)
            begin
                if (sum[i] > 35'(psu_pkg::OUT_MAX))
                    add_reg[i] <= psu_pkg::OUT_MAX;
                else
                    add_reg[i] <= sum[i][psu_pkg::OUT_W-1:0];
            end
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_out
        assign out_data.add[i] = add_reg[i];
    end
endmodule

// ----- design/phong_shading_unit_top.sv -----
// Top level of the Phong shading unit: material registers and the unit chain.
//
//  channel    direction  word                                       handshake
//  sample_ch  in         base color, diffuse factor, N, L           valid/ready
//  color_ch   out        add_red, add_green, add_blue (Q2.15)       valid/ready
//  cfg_*      in         cfg_index, cfg_data                        cfg_we only
//
// One word is accepted per clock while the chain is not stalled. The stages
// are: 6 geometry, 24 square root (one root bit each), 18 divider (a setup
// stage, then one quotient bit each), 8 power (one exponent bit each) and 3 mixing.
// Reset clears the valid bits and loads the material defaults.
// A stall holds only the full stages; empty stages behind it keep filling.
module phong_shading_unit_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    psu_sample_if.sink  sample_ch,
    psu_color_if.source color_ch
);
    logic [15:0] ambient_coef_reg;
    logic [15:0] diffuse_coef_reg;
    logic [15:0] specular_coef_reg;
    logic [7:0]  shininess_reg;

    psu_pkg::psu_smp_t smp;
    psu_pkg::psu_geo_t geo;
    psu_pkg::psu_len_t len;
    psu_pkg::psu_cos_t cos_w;
    psu_pkg::psu_pwr_t pwr;
    psu_pkg::psu_res_t res;
    logic geo_valid, geo_ready;
    logic len_valid, len_ready;
    logic cos_valid, cos_ready;
    logic pwr_valid, pwr_ready;

    // Material registers.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            ambient_coef_reg  <= '0;
            diffuse_coef_reg  <= '0;
            specular_coef_reg <= '0;
            shininess_reg     <= 8'd1;
        end
        else if (cfg_we)
        begin
            unique case (psu_pkg::psu_cfg_e'(cfg_index))
                psu_pkg::CFG_AMBIENT:   ambient_coef_reg  <= cfg_data;
                psu_pkg::CFG_DIFFUSE:   diffuse_coef_reg  <= cfg_data;
                psu_pkg::CFG_SPECULAR:  specular_coef_reg <= cfg_data;
                psu_pkg::CFG_SHININESS: shininess_reg     <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Gather the sample word.
    assign smp.base[0] = sample_ch.base_red;
    assign smp.base[1] = sample_ch.base_green;
    assign smp.base[2] = sample_ch.base_blue;
    assign smp.factor  = sample_ch.diffuse_factor;
    assign smp.n[0]    = sample_ch.normal_x;
    assign smp.n[1]    = sample_ch.normal_y;
    assign smp.n[2]    = sample_ch.normal_z;
    assign smp.l[0]    = sample_ch.light_x;
    assign smp.l[1]    = sample_ch.light_y;
    assign smp.l[2]    = sample_ch.light_z;

    psu_geom u_geom (
        .clk          (clk),
        .rst_n        (rst_n),
        .ambient_coef (ambient_coef_reg),
        .diffuse_coef (diffuse_coef_reg),
        .in_valid     (sample_ch.valid),
        .in_ready     (sample_ch.ready),
        .in_data      (smp),
        .out_valid    (geo_valid),
        .out_ready    (geo_ready),
        .out_data     (geo)
    );

    psu_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (geo_valid),
        .in_ready  (geo_ready),
        .in_data   (geo),
        .out_valid (len_valid),
        .out_ready (len_ready),
        .out_data  (len)
    );

    psu_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (len_valid),
        .in_ready  (len_ready),
        .in_data   (len),
        .out_valid (cos_valid),
        .out_ready (cos_ready),
        .out_data  (cos_w)
    );

    psu_pow u_pow (
        .clk       (clk),
        .rst_n     (rst_n),
        .shininess (shininess_reg),
        .in_valid  (cos_valid),
        .in_ready  (cos_ready),
        .in_data   (cos_w),
        .out_valid (pwr_valid),
        .out_ready (pwr_ready),
        .out_data  (pwr)
    );

    psu_mix u_mix (
        .clk           (clk),
        .rst_n         (rst_n),
        .specular_coef (specular_coef_reg),
        .in_valid      (pwr_valid),
        .in_ready      (pwr_ready),
        .in_data       (pwr),
        .out_valid     (color_ch.valid),
        .out_ready     (color_ch.ready),
        .out_data      (res)
    );

    assign color_ch.add_red   = res.add[0];
    assign color_ch.add_green = res.add[1];
    assign color_ch.add_blue  = res.add[2];
endmodule
